// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the disparity core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is high.
`define SBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbm port check failed");

// Clocked check that also holds across reset.
`define SBM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sbm reset check failed");

`endif

// ----- rtl/sbm_pkg.sv -----
// Shared types and constants of the SAD block-matching disparity core.
package sbm_pkg;

   localparam int PIXEL_W  = 8;
   localparam int DISP_W   = 10;
   localparam int ROW_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISPARITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISPARITY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 3'd4;

   // Input item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] left_pixel;
      logic [PIXEL_W-1:0] right_pixel;
   } req_word_type;

   typedef struct packed {
      logic [DISP_W-1:0] disparity_q4;
      logic              frame_last;
   } rsp_word_type;

   // Control flags of one job handed from front to back
   typedef struct packed {
      logic last;      // final result of the frame
      logic past_end;  // output row beyond the height: zero result
   } job_ctl_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_WAIT,
      BK_DECIDE,
      BK_RESULT
   } back_state_type;

endpackage

// ----- rtl/sbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sbm_fifo.sv -----
// Small register FIFO used for the job queue and the result queue.
module sbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/sbm_front.sv -----
// Front end: takes words, writes the line stores, decides when a result is due.
module sbm_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WINDOW = 11,
   localparam int W_W    = $clog2(MAX_WIDTH + 1),
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int SLOT_W = $clog2(MAX_WINDOW),
   localparam int H_W    = $clog2((MAX_WINDOW - 1) / 2 + 1),
   localparam int THR_W  = H_W + W_W + 1,
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_WINDOW)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  sbm_pkg::req_word_type        req_word,
   input  logic                         hold,
   input  logic [W_W-1:0]               eff_width,
   input  logic [sbm_pkg::ROW_W-1:0]    eff_height,
   input  logic [THR_W-1:0]             lag_thr,
   output logic                         wr_en,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [sbm_pkg::PIXEL_W-1:0]  wr_left,
   output logic [sbm_pkg::PIXEL_W-1:0]  wr_right,
   output logic                         job_push,
   output logic [sbm_pkg::ROW_W-1:0]    job_row,
   output logic [COL_W-1:0]             job_col,
   output logic [SLOT_W-1:0]            job_slot,
   output sbm_pkg::job_ctl_type         job_ctl
);

   localparam int RW     = sbm_pkg::ROW_W;
   localparam int DIFF_W = RW + W_W + 3;

   logic              pend_ff, pend_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0]     in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;

   logic              accept, done_now, done_pend, emit, past_end, last;
   logic [RW:0]       row_diff;
   logic signed [DIFF_W-1:0] lag;

   assign req_full  = pend_ff || hold;
   assign accept    = req_push && !req_full;
   assign done_now  = (in_row_ff >= eff_height);
   assign done_pend = done_now;

   // line store write for a pixel pair of an unfinished frame
   assign wr_en    = accept && (req_word.kind == sbm_pkg::KIND_PIXEL) && !done_now;
   assign wr_addr  = ADDR_W'(in_slot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_ff);
   assign wr_left  = req_word.left_pixel;
   assign wr_right = req_word.right_pixel;

   // raster distance between input and output positions
   assign row_diff = {1'b0, in_row_ff} - {1'b0, out_row_ff};
   assign lag = DIFF_W'($signed(row_diff)) * DIFF_W'($signed({1'b0, eff_width}))
              + DIFF_W'($signed({1'b0, in_col_ff})) - DIFF_W'($signed({1'b0, out_col_ff}));
   assign emit     = pend_ff && (done_pend || (lag > $signed(DIFF_W'(lag_thr))));
   assign past_end = (out_row_ff >= eff_height);

   // counter update: stage one on accept, stage two on the following cycle
   always_comb begin
      pend_in     = accept;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      last        = 1'b0;
      if (wr_en) begin
         if ((W_W'(in_col_ff) + 1'b1) >= eff_width) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 1'b1;
            in_slot_in = (in_slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : in_slot_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      if (emit) begin
         if (past_end) begin
            last = 1'b1;
         end else if ((W_W'(out_col_ff) + 1'b1) >= eff_width) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 1'b1;
            out_slot_in = (out_slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : out_slot_ff + 1'b1;
            last        = ((out_row_ff + 1'b1) >= eff_height);
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
         if (last) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_slot_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   // job handed to the back end
   assign job_push         = emit;
   assign job_row          = out_row_ff;
   assign job_col          = out_col_ff;
   assign job_slot         = out_slot_ff;
   assign job_ctl.last     = last;
   assign job_ctl.past_end = past_end;

endmodule

// ----- rtl/sbm_back.sv -----
// Back end: SAD search over disparities, one pixel pair per cycle in scan.
module sbm_back #(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_WINDOW      = 11,
   parameter int MAX_DISPARITIES = 64,
   localparam int W_W    = $clog2(MAX_WIDTH + 1),
   localparam int COL_W  = $clog2(MAX_WIDTH),
   localparam int SLOT_W = $clog2(MAX_WINDOW),
   localparam int H_W    = $clog2((MAX_WINDOW - 1) / 2 + 1),
   localparam int D_W    = $clog2(MAX_DISPARITIES + 1),
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_WINDOW)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_pop,
   input  logic [sbm_pkg::ROW_W-1:0]    job_row,
   input  logic [COL_W-1:0]             job_col,
   input  logic [SLOT_W-1:0]            job_slot,
   input  sbm_pkg::job_ctl_type         job_ctl,
   input  logic [W_W-1:0]               eff_width,
   input  logic [sbm_pkg::ROW_W-1:0]    eff_height,
   input  logic [H_W-1:0]               eff_half,
   input  logic [5:0]                   disp_lo,
   input  logic [D_W-1:0]               eff_dmax,
   output logic [ADDR_W-1:0]            rd_addr_left,
   output logic [ADDR_W-1:0]            rd_addr_right,
   input  logic [sbm_pkg::PIXEL_W-1:0]  rd_left,
   input  logic [sbm_pkg::PIXEL_W-1:0]  rd_right,
   output logic                         res_push,
   output sbm_pkg::rsp_word_type        res_word,
   input  logic                         res_full,
   output sbm_pkg::back_status_type     status
);

   localparam int RW    = sbm_pkg::ROW_W;
   localparam int XW0   = (COL_W > D_W) ? COL_W : D_W;
   localparam int XW    = ((XW0 > 6) ? XW0 : 6) + 2;
   localparam int ACC_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);

   sbm_pkg::back_state_type state_ff, state_in;

   logic [COL_W-1:0]  x_ff, x_in, c_ff, c_in;
   logic [SLOT_W-1:0] slot0_ff, slot0_in, rslot_ff, rslot_in;
   logic [H_W:0]      rcnt_ff, rcnt_in;
   logic [D_W-1:0]    d_ff, d_in, best_ff, best_in;
   logic [ACC_W-1:0]  acc_ff, acc_in, cost_ff, cost_in;
   logic              found_ff, found_in, last_ff, last_in, rd_valid_ff;

   logic              border, start_ok, row_end, win_end, cont;
   logic [SLOT_W-1:0] slot_start;
   logic [D_W-1:0]    d_next;
   logic [ADDR_W-1:0] base;
   logic [sbm_pkg::PIXEL_W-1:0] absdiff;

   // window reaches past the image edge
   assign border = (job_row < RW'(eff_half))
                || ((RW + 1)'(job_row) + (RW + 1)'(eff_half) >= (RW + 1)'(eff_height))
                || (job_col < COL_W'(eff_half))
                || ((W_W + 1)'(job_col) + (W_W + 1)'(eff_half) >= (W_W + 1)'(eff_width));
   assign start_ok = !job_ctl.past_end && !border
                  && (XW'(disp_lo) < XW'(eff_dmax))
                  && (XW'(job_col) >= XW'(eff_half) + XW'(disp_lo));

   // line-store slot of the top window row
   assign slot_start = (job_slot >= SLOT_W'(eff_half)) ? job_slot - SLOT_W'(eff_half) :
                       SLOT_W'((SLOT_W + 1)'(job_slot) + (SLOT_W + 1)'(MAX_WINDOW)
                               - (SLOT_W + 1)'(eff_half));

   assign row_end = ((COL_W + 1)'(c_ff) == (COL_W + 1)'(x_ff) + (COL_W + 1)'(eff_half));
   assign win_end = row_end && (rcnt_ff == {eff_half, 1'b0});
   assign d_next  = d_ff + 1'b1;
   assign cont    = (d_next < eff_dmax) && (XW'(x_ff) >= XW'(eff_half) + XW'(d_next));

   // read addresses for the current window position
   assign base          = ADDR_W'(rslot_ff) * ADDR_W'(MAX_WIDTH);
   assign rd_addr_left  = base + ADDR_W'(c_ff);
   assign rd_addr_right = base + ADDR_W'(c_ff) - ADDR_W'(d_ff);
   assign absdiff       = (rd_left > rd_right) ? rd_left - rd_right : rd_right - rd_left;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbm_pkg::BK_IDLE: begin
            if (job_valid) begin
               state_in = start_ok ? sbm_pkg::BK_SCAN : sbm_pkg::BK_RESULT;
            end
         end
         sbm_pkg::BK_SCAN: begin
            if (win_end) begin
               state_in = sbm_pkg::BK_WAIT;
            end
         end
         sbm_pkg::BK_WAIT:   state_in = sbm_pkg::BK_DECIDE;
         sbm_pkg::BK_DECIDE: state_in = cont ? sbm_pkg::BK_SCAN : sbm_pkg::BK_RESULT;
         sbm_pkg::BK_RESULT: begin
            if (!res_full) begin
               state_in = sbm_pkg::BK_IDLE;
            end
         end
         default: state_in = sbm_pkg::BK_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      job_pop  = 1'b0;
      res_push = 1'b0;
      case (state_ff)
         sbm_pkg::BK_IDLE:   job_pop  = job_valid;
         sbm_pkg::BK_RESULT: res_push = 1'b1;
         default: begin
            job_pop  = 1'b0;
            res_push = 1'b0;
         end
      endcase
   end

   assign res_word.disparity_q4 = sbm_pkg::DISP_W'({best_ff, 4'b0000});
   assign res_word.frame_last   = last_ff;
   assign status.busy           = (state_ff != sbm_pkg::BK_IDLE);

   // search datapath
   always_comb begin
      x_in     = x_ff;
      c_in     = c_ff;
      slot0_in = slot0_ff;
      rslot_in = rslot_ff;
      rcnt_in  = rcnt_ff;
      d_in     = d_ff;
      best_in  = best_ff;
      cost_in  = cost_ff;
      found_in = found_ff;
      last_in  = last_ff;
      acc_in   = rd_valid_ff ? acc_ff + ACC_W'(absdiff) : acc_ff;
      case (state_ff)
         sbm_pkg::BK_IDLE: begin
            x_in     = job_col;
            c_in     = job_col - COL_W'(eff_half);
            slot0_in = slot_start;
            rslot_in = slot_start;
            rcnt_in  = '0;
            d_in     = D_W'(disp_lo);
            best_in  = '0;
            found_in = 1'b0;
            last_in  = job_ctl.last;
            acc_in   = '0;
         end
         sbm_pkg::BK_SCAN: begin
            if (row_end) begin
               c_in     = x_ff - COL_W'(eff_half);
               rcnt_in  = rcnt_ff + 1'b1;
               rslot_in = (rslot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : rslot_ff + 1'b1;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         sbm_pkg::BK_DECIDE: begin
            // lowest disparity wins ties: replace only on a strictly lower cost
            if (!found_ff || (acc_ff < cost_ff)) begin
               found_in = 1'b1;
               cost_in  = acc_ff;
               best_in  = d_ff;
            end
            acc_in   = '0;
            d_in     = d_next;
            c_in     = x_ff - COL_W'(eff_half);
            rslot_in = slot0_ff;
            rcnt_in  = '0;
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sbm_pkg::BK_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == sbm_pkg::BK_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      c_ff     <= c_in;
      slot0_ff <= slot0_in;
      rslot_ff <= rslot_in;
      rcnt_ff  <= rcnt_in;
      d_ff     <= d_in;
      best_ff  <= best_in;
      cost_ff  <= cost_in;
      found_ff <= found_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
   end

endmodule

// ----- rtl/sad_block_match_disparity_core.sv -----
// Top level of the SAD block-matching stereo disparity core.
//
// Usage: push left/right pixel pairs in raster order on req_word (kind pixel),
// then flush words to drain the frame tail. Each result word on rsp_word is
// one output pixel's disparity times 16, in raster order, with frame_last set
// on the final one; pop takes it while rsp_empty is low.
// Registers are to be written on the csr port only while the block is idle;
// the block does not enforce this. req_full stays high for one cycle after a
// write while the clamped settings settle. The front does not take a new
// word while it is still classifying the last one. A word that completes an
// interior pixel holds req_full high while the back end's SAD loop reads one
// pixel pair per cycle from the two line-store RAMs for each disparity in
// the range. A border pixel skips the search, and a word with no result
// frees the input once the front has classified it.
// The result queue holds two words; when the receiver stops popping, the back
// end waits and req_full stays high until room frees up.
// Reset (synchronous) clears the counters, queues and registers to defaults;
// line stores are not cleared and are only read after being written.
module sad_block_match_disparity_core #(
   parameter int MAX_WIDTH       = 1024,
   parameter int MAX_WINDOW      = 11,
   parameter int MAX_DISPARITIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  sbm_pkg::req_word_type             req_word,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output sbm_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_write,
   input  logic [sbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int H_LIM  = (MAX_WINDOW - 1) / 2;
   localparam int H_W    = $clog2(H_LIM + 1);
   localparam int D_W    = $clog2(MAX_DISPARITIES + 1);
   localparam int THR_W  = H_W + W_W + 1;
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_WINDOW);
   localparam int RW     = sbm_pkg::ROW_W;
   localparam int JOB_W  = RW + COL_W + SLOT_W + $bits(sbm_pkg::job_ctl_type);
   localparam int RSP_W  = $bits(sbm_pkg::rsp_word_type);

   localparam int W_RST   = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int H_RST   = (2 > H_LIM) ? H_LIM : 2;
   localparam int D_RST   = (64 > MAX_DISPARITIES) ? MAX_DISPARITIES : 64;
   localparam int THR_RST = H_RST * W_RST + H_RST;

   // raw configuration registers
   logic [10:0]    width_ff;
   logic [RW-1:0]  height_ff;
   logic [5:0]     dmin_ff;
   logic [6:0]     dmax_ff;
   logic [3:0]     wsize_ff;
   logic           csr_settle_ff;

   // effective (clamped) configuration
   logic [W_W-1:0]   eff_w_ff, eff_w_in;
   logic [RW-1:0]    eff_h_ff, eff_h_in;
   logic [H_W-1:0]   eff_half_ff, eff_half_in;
   logic [D_W-1:0]   eff_dmax_ff, eff_dmax_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
         dmin_ff   <= 6'd0;
         dmax_ff   <= 7'd64;
         wsize_ff  <= 4'd5;
      end else if (csr_write) begin
         case (csr_index)
            sbm_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_data[10:0];
            sbm_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_data[15:0];
            sbm_pkg::CSR_MIN_DISPARITY: dmin_ff   <= csr_data[5:0];
            sbm_pkg::CSR_MAX_DISPARITY: dmax_ff   <= csr_data[6:0];
            sbm_pkg::CSR_WINDOW_SIZE:   wsize_ff  <= csr_data[3:0];
            default: wsize_ff <= wsize_ff;
         endcase
      end
   end

   // input stall for the cycle after a write, until the clamped copies catch up
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_settle_ff <= 1'b0;
      end else begin
         csr_settle_ff <= csr_write;
      end
   end

   // clamping of the configuration
   always_comb begin
      if (width_ff == '0) begin
         eff_w_in = W_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w_in = W_W'(MAX_WIDTH);
      end else begin
         eff_w_in = W_W'(width_ff);
      end
      eff_h_in    = (height_ff == '0) ? RW'(1) : height_ff;
      eff_half_in = (32'(wsize_ff[3:1]) > H_LIM) ? H_W'(H_LIM) : H_W'(wsize_ff[3:1]);
      eff_dmax_in = (32'(dmax_ff) > MAX_DISPARITIES) ? D_W'(MAX_DISPARITIES)
                                                     : D_W'(dmax_ff);
      thr_in = THR_W'(eff_half_in) * THR_W'(eff_w_in) + THR_W'(eff_half_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= W_W'(W_RST);
         eff_h_ff    <= RW'(480);
         eff_half_ff <= H_W'(H_RST);
         eff_dmax_ff <= D_W'(D_RST);
         thr_ff      <= THR_W'(THR_RST);
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         eff_half_ff <= eff_half_in;
         eff_dmax_ff <= eff_dmax_in;
         thr_ff      <= thr_in;
      end
   end

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr_left, rd_addr_right;
   logic [sbm_pkg::PIXEL_W-1:0] wr_left, wr_right, rd_left, rd_right;
   logic                        job_push, job_pop, job_full, job_empty, hold;
   logic [RW-1:0]               job_row_f, job_row_b;
   logic [COL_W-1:0]            job_col_f, job_col_b;
   logic [SLOT_W-1:0]           job_slot_f, job_slot_b;
   sbm_pkg::job_ctl_type        job_ctl_f, job_ctl_b;
   logic                        res_push, res_full;
   sbm_pkg::rsp_word_type       res_word;
   sbm_pkg::back_status_type    back_status;
   logic [RSP_W-1:0]            rsp_bits;

   // input held while a job is queued or in the back end, so stores stay intact
   assign hold = !job_empty || job_full || back_status.busy || csr_settle_ff;

   sbm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .hold       (hold),
      .eff_width  (eff_w_ff),
      .eff_height (eff_h_ff),
      .lag_thr    (thr_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_left    (wr_left),
      .wr_right   (wr_right),
      .job_push   (job_push),
      .job_row    (job_row_f),
      .job_col    (job_col_f),
      .job_slot   (job_slot_f),
      .job_ctl    (job_ctl_f)
   );

   sbm_ram #(
      .WIDTH (sbm_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH * MAX_WINDOW)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_left),
      .rd_addr (rd_addr_left),
      .rd_data (rd_left)
   );

   sbm_ram #(
      .WIDTH (sbm_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH * MAX_WINDOW)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_right),
      .rd_addr (rd_addr_right),
      .rd_data (rd_right)
   );

   sbm_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_row_f, job_col_f, job_slot_f, job_ctl_f}),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  ({job_row_b, job_col_b, job_slot_b, job_ctl_b}),
      .empty     (job_empty)
   );

   sbm_back #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_WINDOW      (MAX_WINDOW),
      .MAX_DISPARITIES (MAX_DISPARITIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (!job_empty),
      .job_pop       (job_pop),
      .job_row       (job_row_b),
      .job_col       (job_col_b),
      .job_slot      (job_slot_b),
      .job_ctl       (job_ctl_b),
      .eff_width     (eff_w_ff),
      .eff_height    (eff_h_ff),
      .eff_half      (eff_half_ff),
      .disp_lo       (dmin_ff),
      .eff_dmax      (eff_dmax_ff),
      .rd_addr_left  (rd_addr_left),
      .rd_addr_right (rd_addr_right),
      .rd_left       (rd_left),
      .rd_right      (rd_right),
      .res_push      (res_push),
      .res_word      (res_word),
      .res_full      (res_full),
      .status        (back_status)
   );

   sbm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_word = sbm_pkg::rsp_word_type'(rsp_bits);

endmodule

// ----- rtl/sbm_checker.sv -----
// Port-level checker for the disparity core, bound to the top level.
`include "assert_macros.svh"

module sbm_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop
);

   // queues and control come out of reset empty and ready
   `SBM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty)
   `SBM_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> !req_full)

   // every accepted word occupies the front for a classify cycle
   `SBM_ASSERT(a_accept_busy, clock, reset, (req_push && !req_full) |=> req_full)

   // a waiting result is not withdrawn
   `SBM_ASSERT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> !rsp_empty)

endmodule

bind sad_block_match_disparity_core sbm_checker u_sbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop)
);

// ----- tb/sv/tb_sad_block_match_disparity_core.sv -----
// Self-checking testbench of the SAD block-matching disparity core.
module tb_sad_block_match_disparity_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_W     = 1024;
   localparam int LINES      = 11;
   localparam int DISP_CAP   = 64;
   localparam int CYCLE_CAP  = 20000000;
   localparam int DRAIN_WAIT = 9000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   sbm_pkg::req_word_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   sbm_pkg::rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [sbm_pkg::CSR_IDX_W-1:0] csr_index = sbm_pkg::CSR_IMAGE_WIDTH;
   logic [sbm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   sad_block_match_disparity_core DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Shadow of the block: registers, counters and line stores
   int unsigned cfg_width = 640, cfg_height = 480, cfg_dmin = 0, cfg_dmax = 64, cfg_window = 5;
   int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
   byte unsigned left_lines [LINES*LINE_W];
   byte unsigned right_lines [LINES*LINE_W];

   sbm_pkg::req_word_type words_to_send [$];
   sbm_pkg::rsp_word_type disparity_due [$];
   int mismatches = 0;
   int cycles = 0;
   bit req_taken = 1'b0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int send_gap = 0;
   int pop_gap = 0;
   int words_queued = 0;

   function automatic int unsigned width_eff();
      if (cfg_width == 0) return 1;
      return (cfg_width > LINE_W) ? LINE_W : cfg_width;
   endfunction

   function automatic int unsigned height_eff();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int unsigned half_eff();
      return (cfg_window / 2 > (LINES - 1) / 2) ? (LINES - 1) / 2 : cfg_window / 2;
   endfunction

   // Lowest-cost disparity of one pixel, times 16
   function automatic int unsigned pixel_disparity(int unsigned y, int unsigned x,
         int unsigned w, int unsigned ht, int unsigned h);
      int unsigned top, best, low_cost, cost, base, a, b;
      bit found;
      top = (cfg_dmax > DISP_CAP) ? DISP_CAP : cfg_dmax;
      best = 0; low_cost = 0; found = 0;
      if (y < h || y + h >= ht || x < h || x + h >= w) return 0;
      for (int unsigned d = cfg_dmin; d < top && x >= h + d; d++) begin
         cost = 0;
         for (int unsigned r = y - h; r <= y + h; r++) begin
            base = (r % LINES) * LINE_W;
            for (int unsigned c = x - h; c <= x + h; c++) begin
               a = left_lines[base + c];
               b = right_lines[base + c - d];
               cost += (a > b) ? a - b : b - a;
            end
         end
         if (!found || cost < low_cost) begin
            found = 1; low_cost = cost; best = d;
         end
      end
      return best * 16;
   endfunction

   // Advance the shadow by one accepted word; queue its result if any
   function automatic void predict_disparity(sbm_pkg::req_word_type wd);
      int unsigned w, ht, h, idx, disp;
      longint unsigned n, o;
      bit done, last;
      sbm_pkg::rsp_word_type r;
      w = width_eff(); ht = height_eff(); h = half_eff();
      done = in_row >= ht;
      disp = 0; last = 0;
      if (wd.kind == sbm_pkg::KIND_PIXEL && !done) begin
         idx = (in_row % LINES) * LINE_W + (in_col % LINE_W);
         left_lines[idx] = wd.left_pixel;
         right_lines[idx] = wd.right_pixel;
         in_col++;
         if (in_col >= w) begin
            in_col = 0; in_row++;
         end
         done = in_row >= ht;
      end
      n = longint'(in_row) * w + in_col;
      o = longint'(out_row) * w + out_col;
      if (!done && n <= o + longint'(h) * w + h) return;
      if (out_row >= ht) last = 1;
      else begin
         disp = pixel_disparity(out_row, out_col, w, ht, h);
         out_col++;
         if (out_col >= w) begin
            out_col = 0; out_row++;
            if (out_row >= ht) last = 1;
         end
      end
      if (last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      r.disparity_q4 = disp[sbm_pkg::DISP_W-1:0];
      r.frame_last = last;
      disparity_due.push_back(r);
   endfunction

   // Driver: words change at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_taken || !req_push) begin
         if (req_taken) void'(words_to_send.pop_front());
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (words_to_send.size() == 0) begin
            req_push <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_word <= words_to_send[0];
         end
      end
   end

   // Receiver: random pop bursts, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         pop_gap = 3000;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         pop_gap = $urandom_range(1, 9) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin
      sbm_pkg::rsp_word_type exp_word;
      req_taken <= !reset && req_push && !req_full;
      if (!reset) begin
         if (req_push && !req_full) predict_disparity(req_word);
         if (rsp_pop && !rsp_empty) begin
            if (disparity_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: disp %0d last %0d",
                     rsp_word.disparity_q4, rsp_word.frame_last);
            end else begin
               exp_word = disparity_due.pop_front();
               if (rsp_word !== exp_word) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected disp %0d last %0d, got disp %0d last %0d",
                        exp_word.disparity_q4, exp_word.frame_last,
                        rsp_word.disparity_q4, rsp_word.frame_last);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [sbm_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[sbm_pkg::CSR_DATA_W-1:0];
      case (idx)
         sbm_pkg::CSR_IMAGE_WIDTH:   cfg_width  = value & 'h7FF;
         sbm_pkg::CSR_IMAGE_HEIGHT:  cfg_height = value & 'hFFFF;
         sbm_pkg::CSR_MIN_DISPARITY: cfg_dmin   = value & 'h3F;
         sbm_pkg::CSR_MAX_DISPARITY: cfg_dmax   = value & 'h7F;
         sbm_pkg::CSR_WINDOW_SIZE:   cfg_window = value & 'hF;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (words_to_send.size() != 0 || req_push || disparity_due.size() != 0)
         @(posedge clock);
   endtask

   // One frame: configure, then pixels, then the words that drain its tail
   task automatic run_frame(int unsigned w, int unsigned ht, int unsigned win,
         int unsigned dmin, int unsigned dmax, bit directed);
      int unsigned we, he, he_half, total, emitted, lag;
      sbm_pkg::req_word_type wd;
      wait_drained();
      repeat (100) @(posedge clock);
      write_reg(sbm_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(sbm_pkg::CSR_IMAGE_HEIGHT, ht);
      write_reg(sbm_pkg::CSR_MIN_DISPARITY, dmin);
      write_reg(sbm_pkg::CSR_MAX_DISPARITY, dmax);
      write_reg(sbm_pkg::CSR_WINDOW_SIZE, win);
      we = width_eff(); he = height_eff(); he_half = half_eff();
      total = we * he;
      lag = he_half * we + he_half;
      emitted = 0;
      for (int unsigned k = 1; k <= total; k++)
         if (k == total || k > emitted + lag) emitted++;
      for (int unsigned k = 0; k < total; k++) begin
         // stray flush before the frame is complete: ignored by the block
         if (!directed && $urandom_range(0, 15) == 0) begin
            wd = {sbm_pkg::KIND_FLUSH, 8'($urandom), 8'($urandom)};
            words_to_send.push_back(wd);
         end
         wd.kind = sbm_pkg::KIND_PIXEL;
         if (directed) begin
            wd.left_pixel = (k % 3 == 0) ? 8'hFF : 8'h00;
            wd.right_pixel = (k % 2 == 0) ? 8'h00 : 8'hFF;
         end else begin
            wd.left_pixel = 8'($urandom);
            wd.right_pixel = 8'($urandom);
         end
         words_to_send.push_back(wd);
      end
      // tail: flushes, some pixels that act as flushes once the frame is in
      for (int unsigned k = emitted; k < total; k++) begin
         wd = {($urandom_range(0, 3) == 0) ? sbm_pkg::KIND_PIXEL : sbm_pkg::KIND_FLUSH,
               8'($urandom), 8'($urandom)};
         words_to_send.push_back(wd);
      end
      words_queued += total + total - emitted;
   endtask

   initial begin
      int unsigned w, ht, win, dmin, dmax;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames: extremes and special register values
      run_frame(5, 3, 3, 0, 4, 1);
      run_frame(0, 0, 0, 63, 127, 0);
      hold_request = 1'b1;
      run_frame(16, 12, 15, 0, 127, 0);
      run_frame(7, 5, 11, 3, 2, 0);
      run_frame(24, 1, 1, 0, 64, 0);
      run_frame(9, 11, 11, 0, 0, 0);

      // random frames, small sizes so interior search stays short
      while (words_queued < 1400) begin
         if (words_queued > 1150) quiet = 1'b1;
         w = $urandom_range(1, 24);
         ht = $urandom_range(1, 12);
         win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
         if ($urandom_range(0, 5) == 0) begin
            dmin = $urandom_range(0, 63);
            dmax = $urandom_range(0, 127);
         end else begin
            dmin = $urandom_range(0, 4);
            dmax = dmin + $urandom_range(0, 8);
         end
         run_frame(w, ht, win, dmin, dmax, 0);
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && disparity_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sbm_pkg.sv
rtl/sbm_ram.sv
rtl/sbm_fifo.sv
rtl/sbm_front.sv
rtl/sbm_back.sv
rtl/sad_block_match_disparity_core.sv
rtl/sbm_checker.sv
tb/sv/tb_sad_block_match_disparity_core.sv
